// ----- design/bcbp_pkg.sv -----
// Shared types and constants for the balanced-variation Bray-Curtis block.
// No dependencies; every other design file imports this package.
package bcbp_pkg;

  // Matrix geometry and value width.
  localparam int ROWS       = 64;
  localparam int COLS       = 64;
  localparam int VALUE_BITS = 16;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = ROWS * COLS;

  // Column counter holds 0 to COLS inclusive.
  localparam int CNT_W = $clog2(COLS + 1);

  // Row sums: COLS values of VALUE_BITS bits each.
  localparam int SUM_W = VALUE_BITS + $clog2(COLS + 1);

  // Q1.16 result.
  localparam int FRAC_BITS = 16;
  localparam int DISS_W    = FRAC_BITS + 1;

  // Item field widths.
  localparam int FLD_ROW_W = 6;
  localparam int FLD_COL_W = 6;
  localparam int FLD_VAL_W = 16;
  localparam int CFG_W     = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Input item.
  typedef struct packed {
    logic                 req_type;
    logic [FLD_ROW_W-1:0] row_a;
    logic [FLD_ROW_W-1:0] row_b;
    logic [FLD_COL_W-1:0] column;
    logic [FLD_VAL_W-1:0] abundance;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [DISS_W-1:0] dissimilarity;
    logic              undefined;
  } rsp_t;

  // Divider command and status.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] numer;
    logic [SUM_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DISS_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- design/bray_curtis_balanced_pair.sv -----
// Balanced-variation Bray-Curtis dissimilarity over a stored abundance matrix.
// Depends on bcbp_pkg and bcbp_div.
//
// Usage:
//   The req channel carries one item per transfer (valid/stall). A write
//   item stores one abundance entry and produces no result, so writes may
//   stream back to back while no query is in progress. A query item names
//   two rows and produces one item on the rsp channel: the Q1.16
//   dissimilarity and an undefined flag that is set (with a zero value)
//   when the denominator is zero.
//   A query walks n = min(cfg, 64) column pairs through the two read ports
//   of the abundance memory, one pair per cycle, then runs a restoring
//   division, which is skipped when the denominator is zero. req_stall is
//   high from acceptance until the result is placed in the output register,
//   so the block takes no new item while a query is in progress.
//   The finished result sits in an output register, so write items are
//   accepted while it waits; a following query stalls at its end until the
//   register is taken. rsp holds steady while rsp_stall is high.
//   cfg_we writes the column count; write it only while no query is active.
//   Reset (rst, synchronous) sets the column count to 64 and empties the
//   output register. The memory is not cleared: entries read by a query
//   must have been written first.
module bray_curtis_balanced_pair (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  bcbp_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output bcbp_pkg::rsp_t                 rsp,
  input  logic                           cfg_we,
  input  logic [bcbp_pkg::CFG_W-1:0]     cfg_wdata
);
  import bcbp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DIFF   = 7'b0000100,
    S_MIN    = 7'b0001000,
    S_LAUNCH = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state;
  state_t            state_next;

  logic [CFG_W-1:0]  cols_cfg;
  logic [CNT_W-1:0]  n_cols;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  k;
  logic [ROW_W-1:0]  row_a_q;
  logic [ROW_W-1:0]  row_b_q;

  logic [VALUE_BITS-1:0] mem [0:DEPTH-1];
  logic [VALUE_BITS-1:0] rdata_a;
  logic [VALUE_BITS-1:0] rdata_b;
  logic                  rd_vld;
  logic                  issue;
  logic [ADDR_W-1:0]     raddr_a;
  logic [ADDR_W-1:0]     raddr_b;
  logic [ADDR_W-1:0]     waddr;

  logic [SUM_W-1:0]  sum_a;
  logic [SUM_W-1:0]  sum_b;
  logic [SUM_W-1:0]  sum_min;
  logic [SUM_W-1:0]  b_q;
  logic [SUM_W-1:0]  c_q;
  logic [SUM_W-1:0]  m_q;
  logic [SUM_W-1:0]  den_q;
  logic [VALUE_BITS-1:0] pair_min;

  rsp_t              res;
  logic              out_free;
  logic              req_acc;
  logic              wr_acc;
  logic              q_acc;

  div_req_t          div_cmd;
  div_rsp_t          div_sts;

  // Handshake decode. New items enter only in the idle state.
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign wr_acc    = req_acc && (req.req_type == REQ_WRITE);
  assign q_acc     = req_acc && (req.req_type == REQ_QUERY);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Column count saturates at the matrix width.
  always_comb begin
    if (32'(cols_cfg) > 32'(COLS)) begin
      n_cols = CNT_W'(COLS);
    end else begin
      n_cols = CNT_W'(cols_cfg);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg <= CFG_RESET;
    end else if (cfg_we) begin
      cols_cfg <= cfg_wdata;
    end
  end

  // Memory addressing: row-major, one write port and two read ports.
  assign issue   = (state == S_SCAN) && (k < n_q);
  assign raddr_a = {row_a_q, k[COL_W-1:0]};
  assign raddr_b = {row_b_q, k[COL_W-1:0]};
  assign waddr   = {req.row_a[ROW_W-1:0], req.column[COL_W-1:0]};

  // Abundance memory. Writes and query reads never share a cycle.
  always_ff @(posedge clk) begin
    if (wr_acc) begin
      mem[waddr] <= req.abundance[VALUE_BITS-1:0];
    end
    if (issue) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

  // Sequencer state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_acc) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !rd_vld) state_next = S_DIFF;
      end
      S_DIFF:   state_next = S_MIN;
      S_MIN:    state_next = S_LAUNCH;
      S_LAUNCH: begin
        if (den_q == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
    end
  end

  // Query capture and column counter.
  always_ff @(posedge clk) begin
    if (q_acc) begin
      row_a_q <= req.row_a[ROW_W-1:0];
      row_b_q <= req.row_b[ROW_W-1:0];
      n_q     <= n_cols;
      k       <= '0;
    end else if (issue) begin
      k <= k + 1'b1;
    end
  end

  // Accumulate row sums and the sum of pairwise minima.
  assign pair_min = (rdata_a < rdata_b) ? rdata_a : rdata_b;

  always_ff @(posedge clk) begin
    if (q_acc) begin
      sum_a   <= '0;
      sum_b   <= '0;
      sum_min <= '0;
    end else if (rd_vld) begin
      sum_a   <= sum_a + SUM_W'(rdata_a);
      sum_b   <= sum_b + SUM_W'(rdata_b);
      sum_min <= sum_min + SUM_W'(pair_min);
    end
  end

  // Balanced and unbalanced parts, then the denominator.
  always_ff @(posedge clk) begin
    if (state == S_DIFF) begin
      b_q <= sum_a - sum_min;
      c_q <= sum_b - sum_min;
    end
    if (state == S_MIN) begin
      m_q   <= (b_q < c_q) ? b_q : c_q;
      den_q <= sum_min + ((b_q < c_q) ? b_q : c_q);
    end
  end

  // Division of min(B,C) by A + min(B,C).
  assign div_cmd.start = (state == S_LAUNCH) && (den_q != '0);
  assign div_cmd.numer = m_q;
  assign div_cmd.denom = den_q;

  bcbp_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .sts (div_sts)
  );

  // Result holding register while the output register is busy.
  always_ff @(posedge clk) begin
    if (state == S_LAUNCH && den_q == '0) begin
      res.dissimilarity <= '0;
      res.undefined     <= 1'b1;
    end else if (state == S_DIV && div_sts.done) begin
      res.dissimilarity <= div_sts.quot;
      res.undefined     <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp <= res;
    end
  end

endmodule

// ----- design/bcbp_div.sv -----
// Restoring divider: floor(numer * 2^16 / denom), one quotient bit per cycle.
// Depends on bcbp_pkg. Requires numer <= denom and denom != 0.
module bcbp_div (
  input  logic               clk,
  input  logic               rst,
  input  bcbp_pkg::div_req_t cmd,
  output bcbp_pkg::div_rsp_t sts
);
  import bcbp_pkg::*;

  localparam int STEP_W = $clog2(DISS_W);

  logic [SUM_W:0]    rem;
  logic [SUM_W-1:0]  den;
  logic [DISS_W-1:0] quot;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;

  // Trial subtraction for the current quotient bit.
  logic              fits;
  logic [SUM_W:0]    diff;

  assign diff = rem - {1'b0, den};
  assign fits = (rem >= {1'b0, den});

  // Control: run DISS_W steps after a start, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= STEP_W'(DISS_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Datapath: the remainder stays below twice the divisor.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= {1'b0, cmd.numer};
      den  <= cmd.denom;
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= {diff[SUM_W-1:0], 1'b0};
      end else begin
        rem <= {rem[SUM_W-1:0], 1'b0};
      end
      quot <= {quot[DISS_W-2:0], fits};
    end
  end

  assign sts.done = done;
  assign sts.quot = quot;

endmodule

// ----- design/bcbp_checker.sv -----
// Port-level checks for bray_curtis_balanced_pair, attached by bind.
// Depends on bcbp_pkg.
module bcbp_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input bcbp_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input bcbp_pkg::rsp_t rsp
);
  import bcbp_pkg::*;

  // A stalled result item stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("result item changed while stalled");

  // An undefined result carries a zero value.
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.undefined |-> rsp.dissimilarity == '0)
    else $error("undefined result with nonzero value");

  // The ratio never exceeds one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.dissimilarity <= DISS_W'(1 << FRAC_BITS))
    else $error("dissimilarity above one");

  // A query occupies the block: no item enters in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.req_type == REQ_QUERY |=> req_stall)
    else $error("item accepted right after a query");

endmodule

bind bray_curtis_balanced_pair bcbp_checker u_bcbp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
